[rtl/core/dh_forward_kinematics_unit_defines.svh]
// Assertion macros for the DH forward kinematics unit.
// Used by the top level only; no other dependencies.
`ifndef DH_FORWARD_KINEMATICS_UNIT_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DHFK_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("dhfk assertion failed");

// Next-cycle implication, disabled during reset.
`define DHFK_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("dhfk assertion failed");

`endif

[rtl/core/dhfk_pkg.sv]
// Shared types, constants and the arctangent table of the DH kinematics unit.
// No dependencies.
`timescale 1ns / 1ps
package dhfk_pkg;
   localparam int Z_W          = 36;
   localparam int XY_W         = 34;
   localparam int R_W          = 32;
   localparam int P_W          = 68;
   localparam int ACC_W        = 70;
   localparam int ROT_OUT_W    = 18;
   localparam int MAX_LINKS    = 6;
   localparam int STEP_W       = 5;
   localparam int CORDIC_STEPS = 20;
   localparam int ROT_MUL_STEPS   = 12;
   localparam int ROT_LAST_STEP   = 13;
   localparam int TRANS_MUL_STEPS = 3;
   localparam int TRANS_LAST_STEP = 3;

   localparam logic signed [Z_W-1:0]  PI_Q30      = 36'sd3373259426;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [R_W-1:0]  ONE_Q30     = 32'sd1073741824;

   typedef logic [3:0] op_type;
   localparam op_type OP_IDLE    = 4'd0;
   localparam op_type OP_ACCEPT  = 4'd1;
   localparam op_type OP_CINIT   = 4'd2;
   localparam op_type OP_CFOLD   = 4'd3;
   localparam op_type OP_CSTEP   = 4'd4;
   localparam op_type OP_CEND    = 4'd5;
   localparam op_type OP_ROT     = 4'd6;
   localparam op_type OP_TRANS   = 4'd7;
   localparam op_type OP_CAPTURE = 4'd8;

   typedef logic [1:0] src_type;
   localparam src_type SRC_THETA = 2'd0;
   localparam src_type SRC_ANGLE = 2'd1;
   localparam src_type SRC_TWIST = 2'd2;

   typedef struct packed {
      op_type              op;
      logic [STEP_W-1:0]   step;
      src_type             src;
      logic [2:0]          link;
   } cmd_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:    atan_q30 = 36'sd843314856;
         5'd1:    atan_q30 = 36'sd497837829;
         5'd2:    atan_q30 = 36'sd263043836;
         5'd3:    atan_q30 = 36'sd133525158;
         5'd4:    atan_q30 = 36'sd67021686;
         5'd5:    atan_q30 = 36'sd33543515;
         5'd6:    atan_q30 = 36'sd16775850;
         5'd7:    atan_q30 = 36'sd8388437;
         5'd8:    atan_q30 = 36'sd4194282;
         5'd9:    atan_q30 = 36'sd2097149;
         5'd10:   atan_q30 = 36'sd1048575;
         5'd11:   atan_q30 = 36'sd524287;
         5'd12:   atan_q30 = 36'sd262143;
         5'd13:   atan_q30 = 36'sd131071;
         5'd14:   atan_q30 = 36'sd65535;
         5'd15:   atan_q30 = 36'sd32767;
         5'd16:   atan_q30 = 36'sd16383;
         5'd17:   atan_q30 = 36'sd8191;
         5'd18:   atan_q30 = 36'sd4095;
         5'd19:   atan_q30 = 36'sd2047;
         default: atan_q30 = '0;
      endcase
   endfunction
endpackage

[rtl/core/dhfk_channels.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
interface dhfk_req_if #(parameter int ANGLE_BITS = 16, parameter int LENGTH_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [2:0]                    joint_or_count;
   logic signed [ANGLE_BITS-1:0]  dh_theta;
   logic signed [LENGTH_BITS-1:0] dh_d;
   logic signed [LENGTH_BITS-1:0] dh_a;
   logic signed [ANGLE_BITS-1:0]  dh_alpha;
   logic signed [ANGLE_BITS-1:0]  angle_j0;
   logic signed [ANGLE_BITS-1:0]  angle_j1;
   logic signed [ANGLE_BITS-1:0]  angle_j2;
   logic signed [ANGLE_BITS-1:0]  angle_j3;
   logic signed [ANGLE_BITS-1:0]  angle_j4;
   logic signed [ANGLE_BITS-1:0]  angle_j5;
   modport source (output valid, action, joint_or_count, dh_theta, dh_d, dh_a, dh_alpha,
                   angle_j0, angle_j1, angle_j2, angle_j3, angle_j4, angle_j5,
                   input ready);
   modport sink (input valid, action, joint_or_count, dh_theta, dh_d, dh_a, dh_alpha,
                 angle_j0, angle_j1, angle_j2, angle_j3, angle_j4, angle_j5,
                 output ready);
endinterface

interface dhfk_rsp_if #(parameter int LENGTH_BITS = 24);
   logic                                    valid;
   logic                                    ready;
   logic signed [dhfk_pkg::ROT_OUT_W-1:0]   rot_00, rot_01, rot_02;
   logic signed [dhfk_pkg::ROT_OUT_W-1:0]   rot_10, rot_11, rot_12;
   logic signed [dhfk_pkg::ROT_OUT_W-1:0]   rot_20, rot_21, rot_22;
   logic signed [LENGTH_BITS-1:0]           pos_x, pos_y, pos_z;
   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface

[rtl/core/dhfk_ctrl.sv]
// Sequencer of the DH kinematics unit: walks links, CORDIC passes, rotations
// and translations, and owns the response valid flag. Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_ctrl #(
   parameter int NUM_JOINTS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_action,
   input  logic [2:0]        in_count,
   input  logic              out_ready,
   output logic              in_ready,
   output logic              out_valid,
   output dhfk_pkg::cmd_type cmd
);
   import dhfk_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CINIT = 3'd1;
   localparam logic [2:0] S_CFOLD = 3'd2;
   localparam logic [2:0] S_CSTEP = 3'd3;
   localparam logic [2:0] S_CEND  = 3'd4;
   localparam logic [2:0] S_ROT   = 3'd5;
   localparam logic [2:0] S_TRANS = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [2:0] LIMIT = 3'(NUM_JOINTS < MAX_LINKS ? NUM_JOINTS : MAX_LINKS);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   src_type           src_ff, src_in;
   logic [2:0]        link_ff, link_in;
   logic [2:0]        count_ff, count_in;
   logic              out_valid_ff, out_valid_in;
   logic              accept, capture;
   logic [2:0]        sat_count;

   assign accept    = in_valid && (state_ff == S_IDLE);
   assign capture   = (state_ff == S_DONE) && (!out_valid_ff || out_ready);
   assign sat_count = (in_count > LIMIT) ? LIMIT : in_count;
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      src_in       = src_ff;
      link_in      = link_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept && in_action) begin
               count_in = sat_count;
               link_in  = '0;
               src_in   = SRC_THETA;
               step_in  = '0;
               state_in = (sat_count == 3'd0) ? S_DONE : S_CINIT;
            end
         end
         S_CINIT: state_in = S_CFOLD;
         S_CFOLD: begin
            step_in  = '0;
            state_in = S_CSTEP;
         end
         S_CSTEP: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_CEND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_CEND: begin
            step_in  = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            if (step_ff == STEP_W'(ROT_LAST_STEP)) begin
               step_in = '0;
               if (src_ff == SRC_TWIST) begin
                  if ((link_ff + 3'd1) == count_ff) begin
                     state_in = S_DONE;
                  end else begin
                     link_in  = link_ff + 3'd1;
                     src_in   = SRC_THETA;
                     state_in = S_CINIT;
                  end
               end else begin
                  state_in = S_TRANS;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_TRANS: begin
            if (step_ff == STEP_W'(TRANS_LAST_STEP)) begin
               step_in  = '0;
               src_in   = src_ff + 2'd1;
               state_in = S_CINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (capture) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.step = step_ff;
      cmd.src  = src_ff;
      cmd.link = link_ff;
      case (state_ff)
         S_IDLE:  cmd.op = accept ? OP_ACCEPT : OP_IDLE;
         S_CINIT: cmd.op = OP_CINIT;
         S_CFOLD: cmd.op = OP_CFOLD;
         S_CSTEP: cmd.op = OP_CSTEP;
         S_CEND:  cmd.op = OP_CEND;
         S_ROT:   cmd.op = OP_ROT;
         S_TRANS: cmd.op = OP_TRANS;
         S_DONE:  cmd.op = capture ? OP_CAPTURE : OP_IDLE;
         default: cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         src_ff       <= SRC_THETA;
         link_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         src_ff       <= src_in;
         link_ff      <= link_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

[rtl/core/dhfk_datapath.sv]
// Datapath of the DH kinematics unit: DH tables, iterative CORDIC, one shared
// multiplier with accumulator, pose registers and response registers. Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_datapath #(
   parameter int NUM_JOINTS  = 6,
   parameter int ANGLE_BITS  = 16,
   parameter int LENGTH_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dhfk_pkg::cmd_type             cmd,
   input  logic                          in_action,
   input  logic [2:0]                    in_joint,
   input  logic signed [ANGLE_BITS-1:0]  in_theta,
   input  logic signed [LENGTH_BITS-1:0] in_d,
   input  logic signed [LENGTH_BITS-1:0] in_a,
   input  logic signed [ANGLE_BITS-1:0]  in_alpha,
   input  logic signed [ANGLE_BITS-1:0]  in_angle [dhfk_pkg::MAX_LINKS],
   output logic signed [dhfk_pkg::ROT_OUT_W-1:0] rot_o [3][3],
   output logic signed [LENGTH_BITS-1:0] pos_o [3]
);
   import dhfk_pkg::*;

   localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int ZSHIFT = 33 - ANGLE_BITS;
   localparam int T_W = 40;
   localparam logic signed [ACC_W-1:0] RND_ACC = 70'sd536870912;
   localparam logic signed [P_W-1:0]   RND_P   = 68'sd536870912;
   localparam logic signed [ACC_W-1:0] ROT_HI  = 70'sd1073741824;
   localparam logic signed [ACC_W-1:0] ROT_LO  = -70'sd1073741824;
   localparam logic signed [R_W-1:0]   RND_OUT = 32'sd8192;
   localparam logic signed [T_W-1:0]   T_HI = (40'sd1 <<< (LENGTH_BITS - 1)) - 40'sd1;
   localparam logic signed [T_W-1:0]   T_LO = -(40'sd1 <<< (LENGTH_BITS - 1));

   function automatic logic signed [R_W-1:0] rot_round(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] sh;
      sh = (v + RND_ACC) >>> 30;
      if (sh > ROT_HI) begin
         sh = ROT_HI;
      end else if (sh < ROT_LO) begin
         sh = ROT_LO;
      end
      return signed'(sh[R_W-1:0]);
   endfunction

   logic signed [ANGLE_BITS-1:0]  theta_ff [NUM_JOINTS], theta_in [NUM_JOINTS];
   logic signed [LENGTH_BITS-1:0] offset_ff [NUM_JOINTS], offset_in [NUM_JOINTS];
   logic signed [LENGTH_BITS-1:0] length_ff [NUM_JOINTS], length_in [NUM_JOINTS];
   logic signed [ANGLE_BITS-1:0]  twist_ff [NUM_JOINTS], twist_in [NUM_JOINTS];
   logic signed [ANGLE_BITS-1:0]  angle_ff [MAX_LINKS], angle_in [MAX_LINKS];
   logic signed [Z_W-1:0]         z_ff, z_in;
   logic signed [XY_W-1:0]        x_ff, x_in, y_ff, y_in, c_ff, c_in, s_ff, s_in;
   logic                          flip_ff, flip_in;
   logic signed [R_W-1:0]         r_ff [3][3], r_in [3][3];
   logic signed [LENGTH_BITS-1:0] t_ff [3], t_in [3];
   logic signed [P_W-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [R_W-1:0]         pnew_ff, pnew_in;
   logic signed [ROT_OUT_W-1:0]   rot_out_ff [3][3], rot_out_in [3][3];
   logic signed [LENGTH_BITS-1:0] pos_out_ff [3], pos_out_in [3];

   logic [IDX_W-1:0]              lidx;
   logic signed [ANGLE_BITS-1:0]  src_angle;
   logic signed [LENGTH_BITS-1:0] len_sel;
   logic signed [Z_W-1:0]         z_raw, z_wrap;
   logic [1:0]                    pcol, qcol, tcol, rk, tk, rj, mj, wbk;
   logic [STEP_W-1:0]             n, m, nw;
   logic                          wb;
   logic signed [XY_W-1:0]        mul_a, mul_b, xs, ys;
   logic signed [P_W-1:0]         prod_w, tsh;
   logic signed [T_W-1:0]         tsum;
   logic signed [R_W+ROT_OUT_W-1:0] rsh;

   assign lidx      = cmd.link[IDX_W-1:0];
   assign src_angle = (cmd.src == SRC_THETA) ? theta_ff[lidx] :
                      (cmd.src == SRC_ANGLE) ? angle_ff[cmd.link] : twist_ff[lidx];
   assign len_sel   = (cmd.src == SRC_THETA) ? offset_ff[lidx] : length_ff[lidx];
   assign z_raw     = Z_W'(src_angle) <<< ZSHIFT;
   assign z_wrap    = (z_raw > PI_Q30) ? z_raw - TWO_PI_Q30 :
                      (z_raw < -PI_Q30) ? z_raw + TWO_PI_Q30 : z_raw;
   assign pcol      = (cmd.src == SRC_TWIST) ? 2'd1 : 2'd0;
   assign qcol      = pcol + 2'd1;
   assign tcol      = (cmd.src == SRC_THETA) ? 2'd2 : 2'd0;
   assign n         = cmd.step;
   assign m         = n - 1'b1;
   assign nw        = n - STEP_W'(5);
   assign mj        = m[1:0];
   assign rj        = n[1:0];
   assign rk        = (n[3:2] == 2'd3) ? 2'd0 : n[3:2];
   assign tk        = (n[1:0] == 2'd3) ? 2'd0 : n[1:0];
   assign wb        = (n == STEP_W'(5)) || (n == STEP_W'(9)) || (n == STEP_W'(13));
   assign wbk       = nw[3:2];
   assign xs        = x_ff >>> n;
   assign ys        = y_ff >>> n;
   assign tsh       = (prod_ff + RND_P) >>> 30;

   always_comb begin
      if (cmd.op == OP_TRANS) begin
         mul_a = XY_W'(r_ff[tk][tcol]);
         mul_b = XY_W'(len_sel);
      end else begin
         mul_a = (rj == 2'd0 || rj == 2'd2) ? c_ff : s_ff;
         mul_b = XY_W'(r_ff[rk][(rj == 2'd0 || rj == 2'd3) ? pcol : qcol]);
      end
   end

   assign prod_w = mul_a * mul_b;

   always_comb begin
      theta_in   = theta_ff;
      offset_in  = offset_ff;
      length_in  = length_ff;
      twist_in   = twist_ff;
      angle_in   = angle_ff;
      z_in       = z_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      c_in       = c_ff;
      s_in       = s_ff;
      flip_in    = flip_ff;
      r_in       = r_ff;
      t_in       = t_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      pnew_in    = pnew_ff;
      rot_out_in = rot_out_ff;
      pos_out_in = pos_out_ff;
      tsum       = '0;
      rsh        = '0;
      case (cmd.op)
         OP_ACCEPT: begin
            if (!in_action) begin
               if (int'(in_joint) < NUM_JOINTS) begin
                  theta_in[in_joint[IDX_W-1:0]]  = in_theta;
                  offset_in[in_joint[IDX_W-1:0]] = in_d;
                  length_in[in_joint[IDX_W-1:0]] = in_a;
                  twist_in[in_joint[IDX_W-1:0]]  = in_alpha;
               end
            end else begin
               angle_in = in_angle;
               for (int i = 0; i < 3; i++) begin
                  t_in[i] = '0;
                  for (int j = 0; j < 3; j++) begin
                     r_in[i][j] = (i == j) ? ONE_Q30 : '0;
                  end
               end
            end
         end
         OP_CINIT: begin
            z_in = z_wrap;
            x_in = CORDIC_GAIN;
            y_in = '0;
         end
         OP_CFOLD: begin
            if (z_ff > HALF_PI_Q30) begin
               z_in    = z_ff - PI_Q30;
               flip_in = 1'b1;
            end else if (z_ff < -HALF_PI_Q30) begin
               z_in    = z_ff + PI_Q30;
               flip_in = 1'b1;
            end else begin
               flip_in = 1'b0;
            end
         end
         OP_CSTEP: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_q30(n);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_q30(n);
            end
         end
         OP_CEND: begin
            c_in = flip_ff ? -x_ff : x_ff;
            s_in = flip_ff ? -y_ff : y_ff;
         end
         OP_ROT: begin
            if (n < STEP_W'(ROT_MUL_STEPS)) begin
               prod_in = prod_w;
            end
            if (n != '0 && n <= STEP_W'(ROT_MUL_STEPS)) begin
               case (mj)
                  2'd0: acc_in = ACC_W'(prod_ff);
                  2'd1: acc_in = acc_ff + ACC_W'(prod_ff);
                  2'd2: begin
                     acc_in  = ACC_W'(prod_ff);
                     pnew_in = rot_round(acc_ff);
                  end
                  default: acc_in = acc_ff - ACC_W'(prod_ff);
               endcase
            end
            if (wb) begin
               r_in[wbk][pcol] = pnew_ff;
               r_in[wbk][qcol] = rot_round(acc_ff);
            end
         end
         OP_TRANS: begin
            if (n < STEP_W'(TRANS_MUL_STEPS)) begin
               prod_in = prod_w;
            end
            if (n != '0) begin
               tsum = T_W'(t_ff[m[1:0]]) + signed'(tsh[T_W-1:0]);
               if (tsum > T_HI) begin
                  tsum = T_HI;
               end else if (tsum < T_LO) begin
                  tsum = T_LO;
               end
               t_in[m[1:0]] = signed'(tsum[LENGTH_BITS-1:0]);
            end
         end
         OP_CAPTURE: begin
            for (int i = 0; i < 3; i++) begin
               pos_out_in[i] = t_ff[i];
               for (int j = 0; j < 3; j++) begin
                  rsh = (R_W + ROT_OUT_W)'(r_ff[i][j] + RND_OUT) >>> 14;
                  rot_out_in[i][j] = signed'(rsh[ROT_OUT_W-1:0]);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            theta_ff[i]  <= '0;
            offset_ff[i] <= '0;
            length_ff[i] <= '0;
            twist_ff[i]  <= '0;
         end
      end else begin
         theta_ff  <= theta_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         twist_ff  <= twist_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff   <= angle_in;
      z_ff       <= z_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      c_ff       <= c_in;
      s_ff       <= s_in;
      flip_ff    <= flip_in;
      r_ff       <= r_in;
      t_ff       <= t_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      pnew_ff    <= pnew_in;
      rot_out_ff <= rot_out_in;
      pos_out_ff <= pos_out_in;
   end

   assign rot_o = rot_out_ff;
   assign pos_o = pos_out_ff;
endmodule

[rtl/core/dh_forward_kinematics_unit.sv]
// DH forward kinematics unit. A load item gives no response. A compute item with
// n links runs, per link, three CORDIC passes, three rotations and two translations
// on one shared multiplier. One compute at a time; a new item is taken while the
// previous response waits.
// Synchronous reset clears the DH tables to zero and the control state.
`timescale 1ns / 1ps
`include "dh_forward_kinematics_unit_defines.svh"
module dh_forward_kinematics_unit #(
   parameter int NUM_JOINTS  = 6,
   parameter int ANGLE_BITS  = 16,
   parameter int LENGTH_BITS = 24
) (
   input logic        clock,
   input logic        reset,
   dhfk_req_if.sink   req_bus,
   dhfk_rsp_if.source rsp_bus
);
   import dhfk_pkg::*;

   cmd_type                       cmd;
   logic                          in_ready;
   logic                          out_valid;
   logic signed [ANGLE_BITS-1:0]  angles [MAX_LINKS];
   logic signed [ROT_OUT_W-1:0]   rot [3][3];
   logic signed [LENGTH_BITS-1:0] pos [3];

   assign angles[0] = req_bus.angle_j0;
   assign angles[1] = req_bus.angle_j1;
   assign angles[2] = req_bus.angle_j2;
   assign angles[3] = req_bus.angle_j3;
   assign angles[4] = req_bus.angle_j4;
   assign angles[5] = req_bus.angle_j5;

   dhfk_ctrl #(.NUM_JOINTS(NUM_JOINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_action (req_bus.action),
      .in_count  (req_bus.joint_or_count),
      .out_ready (rsp_bus.ready),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .cmd       (cmd)
   );

   dhfk_datapath #(
      .NUM_JOINTS  (NUM_JOINTS),
      .ANGLE_BITS  (ANGLE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_action (req_bus.action),
      .in_joint  (req_bus.joint_or_count),
      .in_theta  (req_bus.dh_theta),
      .in_d      (req_bus.dh_d),
      .in_a      (req_bus.dh_a),
      .in_alpha  (req_bus.dh_alpha),
      .in_angle  (angles),
      .rot_o     (rot),
      .pos_o     (pos)
   );

   assign req_bus.ready  = in_ready;
   assign rsp_bus.valid  = out_valid;
   assign rsp_bus.rot_00 = rot[0][0];
   assign rsp_bus.rot_01 = rot[0][1];
   assign rsp_bus.rot_02 = rot[0][2];
   assign rsp_bus.rot_10 = rot[1][0];
   assign rsp_bus.rot_11 = rot[1][1];
   assign rsp_bus.rot_12 = rot[1][2];
   assign rsp_bus.rot_20 = rot[2][0];
   assign rsp_bus.rot_21 = rot[2][1];
   assign rsp_bus.rot_22 = rot[2][2];
   assign rsp_bus.pos_x  = pos[0];
   assign rsp_bus.pos_y  = pos[1];
   assign rsp_bus.pos_z  = pos[2];

   `DHFK_ASSERT_IMPLIES(a_accept_cmd, clock, reset, req_bus.valid && req_bus.ready, cmd.op == OP_ACCEPT)
   `DHFK_ASSERT_NEXT(a_capture_valid, clock, reset, cmd.op == OP_CAPTURE, rsp_bus.valid)
   `DHFK_ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.op == OP_CAPTURE, !rsp_bus.valid || rsp_bus.ready)
endmodule

[tb/dhfk_scoreboard.sv]
// Scoreboard for the DH forward kinematics unit: joint table, fixed-point predictor
// and the queue of expected poses. Depends on dhfk_pkg.
`timescale 1ns / 1ps
package dhfk_tb_pkg;
   import dhfk_pkg::*;

   localparam int ANG_W = 16;
   localparam int LEN_W = 24;
   localparam int N_JOINTS = 6;

   localparam bit ACT_LOAD    = 1'b0;
   localparam bit ACT_COMPUTE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [2:0]        joint_or_count;
      logic [ANG_W-1:0]  dh_theta;
      logic [LEN_W-1:0]  dh_d;
      logic [LEN_W-1:0]  dh_a;
      logic [ANG_W-1:0]  dh_alpha;
      logic [ANG_W-1:0]  angle_j0, angle_j1, angle_j2, angle_j3, angle_j4, angle_j5;
   } req_item_type;

   typedef struct {
      logic [ROT_OUT_W-1:0] rot [9];
      logic [LEN_W-1:0]     pos [3];
   } pose_type;

   class pose_scoreboard;
      longint   theta_tab [N_JOINTS];
      longint   offset_tab [N_JOINTS];
      longint   length_tab [N_JOINTS];
      longint   twist_tab [N_JOINTS];
      pose_type pending_poses [$];
      int       errors;

      function new();
         foreach (theta_tab[i]) begin
            theta_tab[i] = 0;
            offset_tab[i] = 0;
            length_tab[i] = 0;
            twist_tab[i] = 0;
         end
         errors = 0;
      endfunction

      function longint rnd30(longint p);
         longint v;
         v = (p + (64'sd1 <<< 29)) >>> 30;
         if (v > 64'sd1073741824) v = 64'sd1073741824;
         if (v < -64'sd1073741824) v = -64'sd1073741824;
         return v;
      endfunction

      function void sin_cos(longint raw, output longint c, output longint s);
         longint z, x, y, nx, at [20];
         bit flip;
         at = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767, 16383, 8191, 4095, 2047};
         z = raw * (64'sd1 <<< (33 - ANG_W));
         x = 652032874;
         y = 0;
         flip = 0;
         if (z > 64'sd3373259426) z -= 64'sd6746518852;
         if (z < -64'sd3373259426) z += 64'sd6746518852;
         if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
         end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
         end
         for (int i = 0; i < 20; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= at[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += at[i];
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void spin(ref longint r [3][3], input int p, input int q, input longint raw);
         longint c, s, a, b;
         sin_cos(raw, c, s);
         for (int k = 0; k < 3; k++) begin
            a = r[k][p];
            b = r[k][q];
            r[k][p] = rnd30(c * a + s * b);
            r[k][q] = rnd30(c * b - s * a);
         end
      endfunction

      function void shift(ref longint r [3][3], ref longint t [3], input int col,
                          input longint len);
         longint v;
         for (int k = 0; k < 3; k++) begin
            v = t[k] + ((r[k][col] * len + (64'sd1 <<< 29)) >>> 30);
            if (v > 64'sd8388607) v = 64'sd8388607;
            if (v < -64'sd8388608) v = -64'sd8388608;
            t[k] = v;
         end
      endfunction

      function void note_request(req_item_type it);
         longint r [3][3];
         longint t [3];
         longint ang [6];
         int n;
         pose_type e;
         if (it.action == ACT_LOAD) begin
            if (it.joint_or_count < N_JOINTS) begin
               theta_tab[it.joint_or_count] = longint'($signed(it.dh_theta));
               offset_tab[it.joint_or_count] = longint'($signed(it.dh_d));
               length_tab[it.joint_or_count] = longint'($signed(it.dh_a));
               twist_tab[it.joint_or_count] = longint'($signed(it.dh_alpha));
            end
            return;
         end
         ang = '{$signed(it.angle_j0), $signed(it.angle_j1), $signed(it.angle_j2),
                 $signed(it.angle_j3), $signed(it.angle_j4), $signed(it.angle_j5)};
         r = '{'{64'sd1073741824, 0, 0}, '{0, 64'sd1073741824, 0},
               '{0, 0, 64'sd1073741824}};
         t = '{0, 0, 0};
         n = (it.joint_or_count > N_JOINTS) ? N_JOINTS : it.joint_or_count;
         for (int i = 0; i < n; i++) begin
            spin(r, 0, 1, theta_tab[i]);
            shift(r, t, 2, offset_tab[i]);
            spin(r, 0, 1, ang[i]);
            shift(r, t, 0, length_tab[i]);
            spin(r, 1, 2, twist_tab[i]);
         end
         for (int j = 0; j < 9; j++)
            e.rot[j] = ROT_OUT_W'((r[j / 3][j % 3] + 64'sd8192) >>> 14);
         for (int k = 0; k < 3; k++) e.pos[k] = LEN_W'(t[k]);
         pending_poses.insert(pending_poses.size(), e);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_pose(pose_type got);
         pose_type e;
         if (pending_poses.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
            return;
         end
         e = pending_poses.pop_front();
         for (int j = 0; j < 9; j++)
            if (got.rot[j] !== e.rot[j])
               report_mismatch($sformatf("rot_%0d%0d", j / 3, j % 3),
                               $signed(got.rot[j]), $signed(e.rot[j]));
         for (int k = 0; k < 3; k++)
            if (got.pos[k] !== e.pos[k])
               report_mismatch($sformatf("pos_%0d", k), $signed(got.pos[k]),
                               $signed(e.pos[k]));
      endtask
   endclass
endpackage

[tb/tb_top.sv]
// Top of the DH forward kinematics testbench: clock, reset, stimulus and response
// check. Depends on dhfk_pkg, dhfk_channels, dhfk_tb_pkg and the unit.
`timescale 1ns / 1ps
module tb_top;
   import dhfk_pkg::*;
   import dhfk_tb_pkg::*;

   logic clock;
   logic reset;
   int   send_idle_pct, recv_stall_pct;
   longint cycles;
   pose_scoreboard board;

   dhfk_req_if #(.ANGLE_BITS(16), .LENGTH_BITS(24)) req_bus ();
   dhfk_rsp_if #(.LENGTH_BITS(24)) rsp_bus ();

   dh_forward_kinematics_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 64'd3000000) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic drive_idle();
      req_bus.valid <= 0;
      req_bus.action <= 0;
      req_bus.joint_or_count <= 0;
      req_bus.dh_theta <= 0;
      req_bus.dh_d <= 0;
      req_bus.dh_a <= 0;
      req_bus.dh_alpha <= 0;
      req_bus.angle_j0 <= 0;
      req_bus.angle_j1 <= 0;
      req_bus.angle_j2 <= 0;
      req_bus.angle_j3 <= 0;
      req_bus.angle_j4 <= 0;
      req_bus.angle_j5 <= 0;
   endtask

   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.action <= it.action;
      req_bus.joint_or_count <= it.joint_or_count;
      req_bus.dh_theta <= it.dh_theta;
      req_bus.dh_d <= it.dh_d;
      req_bus.dh_a <= it.dh_a;
      req_bus.dh_alpha <= it.dh_alpha;
      req_bus.angle_j0 <= it.angle_j0;
      req_bus.angle_j1 <= it.angle_j1;
      req_bus.angle_j2 <= it.angle_j2;
      req_bus.angle_j3 <= it.angle_j3;
      req_bus.angle_j4 <= it.angle_j4;
      req_bus.angle_j5 <= it.angle_j5;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(it);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_angle(bit wide);
      int v;
      case ($urandom_range(9))
         0: v = 25736;
         1: v = -25736;
         2: v = 0;
         default: v = $urandom_range(51472) - 25736;
      endcase
      if (wide && $urandom_range(7) == 0) return 16'($urandom);
      return 16'(v);
   endfunction

   function automatic logic [23:0] pick_length();
      case ($urandom_range(7))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2: return 24'($urandom_range(2097152)) - 24'd1048576;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_item_type rand_item(bit act, int sel);
      req_item_type it;
      it = req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.action = act;
      it.joint_or_count = 3'(sel);
      it.dh_theta = pick_angle(1);
      it.dh_alpha = pick_angle(1);
      it.dh_d = pick_length();
      it.dh_a = pick_length();
      it.angle_j0 = pick_angle(1);
      it.angle_j1 = pick_angle(1);
      it.angle_j2 = pick_angle(1);
      it.angle_j3 = pick_angle(1);
      it.angle_j4 = pick_angle(1);
      it.angle_j5 = pick_angle(1);
      return it;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      pose_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.rot = '{rsp_bus.rot_00, rsp_bus.rot_01, rsp_bus.rot_02, rsp_bus.rot_10,
                     rsp_bus.rot_11, rsp_bus.rot_12, rsp_bus.rot_20, rsp_bus.rot_21,
                     rsp_bus.rot_22};
         got.pos = '{rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.pos_z};
         board.check_pose(got);
      end
   end

   initial begin
      req_item_type it;
      board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      drive_idle();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, empty table, ignored loads, count saturation
      for (int n = 0; n <= 7; n += 7) send_item(rand_item(ACT_COMPUTE, n));
      for (int j = 0; j < 8; j++) begin
         it = rand_item(ACT_LOAD, j);
         it.dh_theta = (j % 2) ? 16'sd25736 : -16'sd25736;
         it.dh_alpha = (j % 2) ? -16'sd25736 : 16'sd25736;
         it.dh_d = (j % 2) ? 24'h7fffff : 24'h800000;
         it.dh_a = (j % 2) ? 24'h800000 : 24'h7fffff;
         send_item(it);
      end
      for (int n = 0; n < 8; n++) begin
         it = rand_item(ACT_COMPUTE, n);
         if (n == 3) {it.angle_j0, it.angle_j1, it.angle_j2} = {3{16'h7fff}};
         if (n == 4) {it.angle_j0, it.angle_j1, it.angle_j2, it.angle_j3} = {4{16'h8000}};
         send_item(it);
      end
      send_item(rand_item(ACT_COMPUTE, 6));

      // random: phases of idling and response stalls, table reloads between computes
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 17) : 0;
         recv_stall_pct = (ph == 2) ? 45 : ((ph == 3) ? 17 : 0);
         for (int i = 0; i < 270; i++) begin
            if ($urandom_range(99) < 40)
               send_item(rand_item(ACT_LOAD, $urandom_range(99) < 90 ?
                                   $urandom_range(5) : $urandom_range(7)));
            else
               send_item(rand_item(ACT_COMPUTE, $urandom_range(99) < 70 ?
                                   $urandom_range(2) : $urandom_range(7)));
         end
      end
      req_bus.valid <= 0;

      while (board.pending_poses.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (board.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
